// ===== src/rapob_pkg.sv =====
// Shared constants and types for the RA prefix option builder.
`timescale 1ns / 1ps
`default_nettype none

package rapob_pkg;

   // Option slots the store can hold.
   localparam int MaxPrefixOptions = 32;
   localparam int SlotIdxW = (MaxPrefixOptions > 1) ? $clog2(MaxPrefixOptions) : 1;
   localparam int CntW = $clog2(MaxPrefixOptions + 1);

   // Stored entry: masked prefix high, masked prefix low, 7-bit length.
   localparam int PrefixLenW = 7;
   localparam int EntryW = 64 + 64 + PrefixLenW;

   // Configuration port.
   localparam int PaddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic RegTargetIfindex = 1'b0;
   localparam logic RegSlotsAvailable = 1'b1;
   localparam logic [5:0] SlotsAvailableReset = 6'd32;

   // Link-local prefix fe80::/10 seen in the top ten address bits.
   localparam logic [9:0] LinkLocalTop = 10'h3fa;
   localparam logic [7:0] MaxLenExcl = 8'd128;
   localparam logic [7:0] HalfLen = 8'd64;

   typedef enum logic [2:0] {
      StEmitted   = 3'd0,
      StOtherIf   = 3'd1,
      StLinkLocal = 3'd2,
      StTooLong   = 3'd3,
      StDuplicate = 3'd4,
      StNoSlot    = 3'd5
   } status_type;

endpackage

`default_nettype wire

// ===== src/rapob_if.sv =====
// Request and response channel interfaces of the RA prefix option builder.
`timescale 1ns / 1ps
`default_nettype none

interface rapob_req_if;
   logic        valid;
   logic        ready;
   logic        new_advert;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic [31:0] entry_ifindex;
   logic [7:0]  entry_prefix_len;

   modport source (output valid, new_advert, addr_high, addr_low, entry_ifindex,
                   entry_prefix_len, input ready);
   modport sink (input valid, new_advert, addr_high, addr_low, entry_ifindex,
                 entry_prefix_len, output ready);
endinterface

interface rapob_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] prefix_high;
   logic [63:0] prefix_low;
   logic [6:0]  prefix_bits;
   logic        autonomous;
   logic [4:0]  slot;

   modport source (output valid, status, prefix_high, prefix_low, prefix_bits, autonomous,
                   slot, input ready);
   modport sink (input valid, status, prefix_high, prefix_low, prefix_bits, autonomous,
                 slot, output ready);
endinterface

`default_nettype wire

// ===== src/rapob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rapob_ram #(
   parameter int Width = 8,
   parameter int Depth = 32,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [Width-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr,
   output      logic [Width-1:0] rdata
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== src/ra_prefix_option_builder_top.sv =====
// Top level of the RA prefix option builder: checks, masks and de-duplicates prefixes.
// Flow: an accepted entry is checked in StCheck; a rejected one goes straight to StFinish,
//   a searched one first walks the N prefixes emitted so far in StScan, one RAM read a cycle.
// Throughput: one entry in flight; the next is taken once StFinish has loaded the result
//   into the output register, which waits while that register is stalled.
// Reset (synchronous, active high): idle, no result, count 0, config registers at reset values.
`timescale 1ns / 1ps
`default_nettype none

module ra_prefix_option_builder_top
   import rapob_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   rapob_req_if.sink              req_bus,
   rapob_rsp_if.source            rsp_bus,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [PaddrW-1:0] paddr,
   input  wire logic [CsrDataW-1:0] pwdata,
   output      logic [CsrDataW-1:0] prdata,
   output      logic              pready
);

   typedef enum logic [1:0] {
      StIdle,
      StCheck,
      StScan,
      StFinish
   } state_type;

   // All-ones in the top n bits of a 64-bit word; n of 64 or more gives all-ones.
   function automatic logic [63:0] top_mask(input logic [6:0] n);
      top_mask = ~({64{1'b1}} >> n);
   endfunction

   // Control state.
   state_type            state_ff, state_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [CntW-1:0]      rd_idx_ff, rd_idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          target_ff, target_in;
   logic [5:0]           slots_ff, slots_in;

   // Entry payload held while the entry is worked on.
   logic [63:0]          ahi_ff, ahi_in;
   logic [63:0]          alo_ff, alo_in;
   logic [31:0]          ifx_ff, ifx_in;
   logic [7:0]           len_ff, len_in;
   logic [63:0]          phi_ff, phi_in;
   logic [63:0]          plo_ff, plo_in;
   status_type           status_ff, status_in;

   // Output register.
   status_type           out_status_ff, out_status_in;
   logic [63:0]          out_phi_ff, out_phi_in;
   logic [63:0]          out_plo_ff, out_plo_in;
   logic [6:0]           out_bits_ff, out_bits_in;
   logic                 out_auto_ff, out_auto_in;
   logic [4:0]           out_slot_ff, out_slot_in;

   // Prefix RAM access.
   logic                 ram_we;
   logic                 ram_re;
   logic [EntryW-1:0]    ram_rdata;
   logic [EntryW-1:0]    probe;
   logic                 issue;
   logic                 hit;

   logic                 req_beat;
   logic                 cfg_write;
   logic                 out_free;
   logic [7:0]           limit;

   assign req_bus.ready = (state_ff == StIdle);
   assign req_beat = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.prefix_high = out_phi_ff;
   assign rsp_bus.prefix_low  = out_plo_ff;
   assign rsp_bus.prefix_bits = out_bits_ff;
   assign rsp_bus.autonomous  = out_auto_ff;
   assign rsp_bus.slot        = out_slot_ff;

   // Configuration: writes land on the access phase; the register index is address bit 2.
   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr[2])
         RegTargetIfindex:  prdata = target_ff;
         RegSlotsAvailable: prdata = CsrDataW'(slots_ff);
         default:           prdata = '0;
      endcase
   end

   // Usable slots: the smaller of the register and the store depth.
   assign limit = (8'(slots_ff) > 8'(MaxPrefixOptions)) ? 8'(MaxPrefixOptions)
                                                       : 8'(slots_ff);

   // Search: issue one read a cycle, compare the word read in the previous cycle.
   assign issue = (state_ff == StScan) && (rd_idx_ff < cnt_ff);
   assign ram_re = issue;
   assign probe = {phi_ff, plo_ff, len_ff[PrefixLenW-1:0]};
   assign hit = cmp_valid_ff && (ram_rdata == probe);
   assign ram_we = (state_ff == StFinish) && out_free && (status_ff == StEmitted);

   rapob_ram #(
      .Width (EntryW),
      .Depth (MaxPrefixOptions)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff[SlotIdxW-1:0]),
      .wdata (probe),
      .re    (ram_re),
      .raddr (rd_idx_ff[SlotIdxW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_valid_in  = 1'b0;
      target_in     = target_ff;
      slots_in      = slots_ff;
      ahi_in        = ahi_ff;
      alo_in        = alo_ff;
      ifx_in        = ifx_ff;
      len_in        = len_ff;
      phi_in        = phi_ff;
      plo_in        = plo_ff;
      status_in     = status_ff;
      out_status_in = out_status_ff;
      out_phi_in    = out_phi_ff;
      out_plo_in    = out_plo_ff;
      out_bits_in   = out_bits_ff;
      out_auto_in   = out_auto_ff;
      out_slot_in   = out_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      if (cfg_write) begin
         unique case (paddr[2])
            RegTargetIfindex:  target_in = pwdata;
            RegSlotsAvailable: slots_in = pwdata[5:0];
            default:           target_in = target_ff;
         endcase
      end

      unique case (state_ff)
         StIdle: begin
            if (req_beat) begin
               ahi_in = req_bus.addr_high;
               alo_in = req_bus.addr_low;
               ifx_in = req_bus.entry_ifindex;
               len_in = req_bus.entry_prefix_len;
               // Drop the stored prefixes when a new advertisement opens.
               if (req_bus.new_advert) begin
                  cnt_in = '0;
               end
               state_in = StCheck;
            end
         end
         StCheck: begin
            if (len_ff <= HalfLen) begin
               phi_in = ahi_ff & top_mask(len_ff[6:0]);
               plo_in = '0;
            end else begin
               phi_in = ahi_ff;
               plo_in = alo_ff & top_mask(7'(len_ff[6:0] - 7'(HalfLen)));
            end
            rd_idx_in = '0;
            priority if (ifx_ff != target_ff) begin
               status_in = StOtherIf;
               state_in  = StFinish;
            end else if (ahi_ff[63:54] == LinkLocalTop) begin
               status_in = StLinkLocal;
               state_in  = StFinish;
            end else if (len_ff >= MaxLenExcl) begin
               status_in = StTooLong;
               state_in  = StFinish;
            end else if (8'(cnt_ff) >= limit) begin
               status_in = StNoSlot;
               state_in  = StFinish;
            end else begin
               status_in = StEmitted;
               state_in  = StScan;
            end
         end
         StScan: begin
            cmp_valid_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (hit) begin
               status_in = StDuplicate;
               state_in  = StFinish;
            end else if (!issue && !cmp_valid_ff) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            // Hold the result until the output register is free.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = status_ff;
               if (status_ff == StEmitted) begin
                  out_phi_in  = phi_ff;
                  out_plo_in  = plo_ff;
                  out_bits_in = len_ff[6:0];
                  out_auto_in = (len_ff == HalfLen);
                  out_slot_in = 5'(cnt_ff);
                  cnt_in      = cnt_ff + 1'b1;
               end else begin
                  out_phi_in  = '0;
                  out_plo_in  = '0;
                  out_bits_in = '0;
                  out_auto_in = 1'b0;
                  out_slot_in = '0;
               end
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         slots_ff     <= SlotsAvailableReset;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         slots_ff     <= slots_in;
      end
      ahi_ff        <= ahi_in;
      alo_ff        <= alo_in;
      ifx_ff        <= ifx_in;
      len_ff        <= len_in;
      phi_ff        <= phi_in;
      plo_ff        <= plo_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_phi_ff    <= out_phi_in;
      out_plo_ff    <= out_plo_in;
      out_bits_ff   <= out_bits_in;
      out_auto_ff   <= out_auto_in;
      out_slot_ff   <= out_slot_in;
   end

endmodule

`default_nettype wire

// ===== src/rapob_checker.sv =====
// Port-level assertions for the RA prefix option builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rapob_checker
   import rapob_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [63:0] rsp_prefix_high,
   input wire logic [63:0] rsp_prefix_low,
   input wire logic [6:0]  rsp_prefix_bits,
   input wire logic        rsp_autonomous,
   input wire logic [4:0]  rsp_slot
);

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_prefix_high) && $stable(rsp_prefix_low) && $stable(rsp_slot))
      else $error("response beat changed while stalled");

   // Rejected entries carry an all-zero option.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StEmitted |-> rsp_prefix_high == '0
         && rsp_prefix_low == '0 && rsp_prefix_bits == '0 && !rsp_autonomous
         && rsp_slot == '0)
      else $error("rejected entry carries option fields");

   // Autonomous flag follows a 64-bit prefix length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StEmitted |-> rsp_autonomous == (rsp_prefix_bits == 7'd64))
      else $error("autonomous flag disagrees with prefix length");

   // Only defined status codes are returned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= StNoSlot)
      else $error("undefined status code");

   // No response beat right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ra_prefix_option_builder_top rapob_checker u_rapob_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_prefix_high (rsp_bus.prefix_high),
   .rsp_prefix_low  (rsp_bus.prefix_low),
   .rsp_prefix_bits (rsp_bus.prefix_bits),
   .rsp_autonomous  (rsp_bus.autonomous),
   .rsp_slot        (rsp_bus.slot)
);

`default_nettype wire
